>>> src/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds command codes, state and control encodings, and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int POS_W     = 11;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W = 1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BLANK      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LOW  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HIGH = 8'h7e;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;

    // Attribute reset values
    localparam logic [ATTR_W-1:0] RESET_CELL_ATTR    = 8'h0f;
    localparam logic [ATTR_W-1:0] RESET_DEFAULT_ATTR = 8'h07;
    localparam logic [ATTR_W-1:0] RESET_FILL_ATTR    = 8'h0f;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT,
        CMD_CLEAR,
        CMD_SET_CURSOR,
        CMD_READ
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_ATTR,
        CFG_FILL_ATTR
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_NEWLINE,
        S_BS_RD,
        S_BS_WR,
        S_PUT_WR,
        S_READ_WAIT,
        S_CLEAR,
        S_FINISH,
        S_SCR_PRIME,
        S_SCR_COPY,
        S_SCR_FILL,
        S_EMIT
    } t_state;

    // Position update
    typedef enum logic [1:0] {
        AT_HOLD,
        AT_INC,
        AT_DEC,
        AT_NEWLINE
    } t_at_op;

    // Memory read address select
    typedef enum logic [2:0] {
        RD_NONE,
        RD_AT,
        RD_POS,
        RD_COPY,
        RD_COPY_NEXT
    } t_rd;

    // Memory write source select
    typedef enum logic [2:0] {
        WR_NONE,
        WR_PUT,
        WR_PUT_KEEP,
        WR_BLANK_KEEP,
        WR_SWEEP_BLANK,
        WR_COPY,
        WR_FILL
    } t_wr;

    // Cursor update
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_SET,
        CUR_MOVE
    } t_cur_op;

    typedef struct packed {
        logic    load;
        logic    div_init;
        t_at_op  at_op;
        t_rd     rd;
        t_wr     wr;
        logic    sweep_inc;
        t_cur_op cur_op;
        logic    capture;
        logic    emit;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic is_newline;
        logic is_backspace;
        logic is_printable;
        logic at_zero;
        logic at_on_screen;
        logic attr_zero;
        logic move;
        logic pos_on_screen;
        logic sweep_last;
        logic sweep_last_copy;
    } t_status;

endpackage

`default_nettype wire

>>> src/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Holds the screen cells. No dependencies beyond the package defaults.
`default_nettype none

module tcw_ram #(
    parameter int  WIDTH  = tcw_pkg::CELL_W,
    parameter int  DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/tcw_ctrl.sv
// Controller state machine for the text console writer.
// Sequences each command through the datapath; uses tcw_pkg.
`default_nettype none

module tcw_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire tcw_pkg::t_status i_status,
    output tcw_pkg::t_ctl         o_ctl,
    output logic                  o_busy
);

    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_status.cmd)
                    CMD_PUT: begin
                        if (i_status.is_newline) begin
                            n_state = S_NEWLINE;
                        end else if (i_status.is_backspace) begin
                            n_state = i_status.at_zero ? S_FINISH : S_BS_RD;
                        end else if (i_status.is_printable && i_status.at_on_screen
                                     && i_status.attr_zero) begin
                            n_state = S_PUT_WR;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                    CMD_CLEAR:      n_state = S_CLEAR;
                    CMD_SET_CURSOR: n_state = S_EMIT;
                    CMD_READ:       n_state = i_status.pos_on_screen ? S_READ_WAIT : S_EMIT;
                    default:        n_state = S_EMIT;
                endcase
            end
            S_NEWLINE:   n_state = S_FINISH;
            S_BS_RD:     n_state = i_status.at_on_screen ? S_BS_WR : S_FINISH;
            S_BS_WR:     n_state = S_FINISH;
            S_PUT_WR:    n_state = S_FINISH;
            S_READ_WAIT: n_state = S_EMIT;
            S_CLEAR: begin
                if (i_status.sweep_last) n_state = S_EMIT;
            end
            S_FINISH: begin
                if (i_status.move && !i_status.at_on_screen) begin
                    n_state = S_SCR_PRIME;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCR_PRIME: n_state = S_SCR_COPY;
            S_SCR_COPY: begin
                if (i_status.sweep_last_copy) n_state = S_SCR_FILL;
            end
            S_SCR_FILL: begin
                if (i_status.sweep_last) n_state = S_EMIT;
            end
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_ctl.load      = 1'b0;
        o_ctl.div_init  = 1'b0;
        o_ctl.at_op     = AT_HOLD;
        o_ctl.rd        = RD_NONE;
        o_ctl.wr        = WR_NONE;
        o_ctl.sweep_inc = 1'b0;
        o_ctl.cur_op    = CUR_HOLD;
        o_ctl.capture   = 1'b0;
        o_ctl.emit      = 1'b0;
        case (r_state)
            S_INIT: begin
                o_ctl.wr        = WR_SWEEP_BLANK;
                o_ctl.sweep_inc = 1'b1;
            end
            S_IDLE: begin
                o_ctl.load = i_start;
            end
            S_DECODE: begin
                case (i_status.cmd)
                    CMD_PUT: begin
                        if (i_status.is_newline) begin
                            o_ctl.div_init = 1'b1;
                        end else if (i_status.is_backspace) begin
                            if (!i_status.at_zero) o_ctl.at_op = AT_DEC;
                        end else if (i_status.is_printable) begin
                            if (!i_status.at_on_screen) begin
                                o_ctl.at_op = AT_INC;
                            end else if (!i_status.attr_zero) begin
                                o_ctl.wr    = WR_PUT;
                                o_ctl.at_op = AT_INC;
                            end else begin
                                o_ctl.rd = RD_AT;
                            end
                        end
                    end
                    CMD_CLEAR:      o_ctl.cur_op = CUR_ZERO;
                    CMD_SET_CURSOR: o_ctl.cur_op = CUR_SET;
                    CMD_READ: begin
                        if (i_status.pos_on_screen) o_ctl.rd = RD_POS;
                    end
                    default: o_ctl.cur_op = CUR_HOLD;
                endcase
            end
            S_NEWLINE: begin
                o_ctl.at_op = AT_NEWLINE;
            end
            S_BS_RD: begin
                if (i_status.at_on_screen) o_ctl.rd = RD_AT;
            end
            S_BS_WR: begin
                o_ctl.wr = WR_BLANK_KEEP;
            end
            S_PUT_WR: begin
                o_ctl.wr    = WR_PUT_KEEP;
                o_ctl.at_op = AT_INC;
            end
            S_READ_WAIT: begin
                o_ctl.capture = 1'b1;
            end
            S_CLEAR: begin
                o_ctl.wr        = WR_SWEEP_BLANK;
                o_ctl.sweep_inc = 1'b1;
            end
            S_FINISH: begin
                if (i_status.move) o_ctl.cur_op = CUR_MOVE;
            end
            S_SCR_PRIME: begin
                o_ctl.rd = RD_COPY;
            end
            S_SCR_COPY: begin
                o_ctl.wr        = WR_COPY;
                o_ctl.rd        = i_status.sweep_last_copy ? RD_NONE : RD_COPY_NEXT;
                o_ctl.sweep_inc = 1'b1;
            end
            S_SCR_FILL: begin
                o_ctl.wr        = WR_FILL;
                o_ctl.sweep_inc = 1'b1;
            end
            S_EMIT: begin
                o_ctl.emit = 1'b1;
            end
            default: o_ctl.emit = 1'b0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> src/tcw_datapath.sv
// Datapath of the text console writer: item registers, cursor, sweep
// counter, newline row quotient (reciprocal multiply) and the screen RAM (tcw_ram).
// Uses tcw_pkg; driven by tcw_ctrl through t_ctl / t_status.
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]      i_cfg_data,
    input  wire logic [tcw_pkg::CMD_W-1:0]       i_command,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      i_character,
    input  wire logic [tcw_pkg::ATTR_W-1:0]      i_attribute,
    input  wire logic                            i_use_cursor,
    input  wire logic [tcw_pkg::POS_W-1:0]       i_position,
    input  wire logic                            i_move_cursor,
    input  wire tcw_pkg::t_ctl                   i_ctl,
    output tcw_pkg::t_status                     o_status,
    output logic                                 o_done,
    output logic      [tcw_pkg::POS_W-1:0]       o_cursor,
    output logic      [tcw_pkg::CHAR_W-1:0]      o_cell_character,
    output logic      [tcw_pkg::ATTR_W-1:0]      o_cell_attribute,
    output logic                                 o_scrolled
);

    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int PW         = ((AW > POS_W) ? AW : POS_W) + 1;

    // Reciprocal of the column count, exact for every PW-bit position
    localparam int          LOG_C   = $clog2(COLUMNS);
    localparam int          SHIFT   = PW + LOG_C;
    localparam longint      RECIP_L = ((longint'(1) << SHIFT) + longint'(COLUMNS) - 1)
                                      / longint'(COLUMNS);
    localparam logic [PW:0] RECIP   = (PW + 1)'(RECIP_L);
    localparam int          PROD_W  = 2 * PW + 1;

    localparam logic [PW-1:0] COLS_P         = PW'(COLUMNS);
    localparam logic [PW-1:0] CELLS_P        = PW'(CELL_COUNT);
    localparam logic [AW-1:0] COLS_A         = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL      = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] LAST_ROW_START = AW'(CELL_COUNT - COLUMNS);
    localparam logic [AW-1:0] LAST_COPY      = AW'(CELL_COUNT - COLUMNS - 1);

    // Configuration
    logic [ATTR_W-1:0] r_def_attr;
    logic [ATTR_W-1:0] r_fill_attr;

    // Item registers
    t_cmd              r_cmd;
    logic [CHAR_W-1:0] r_ch;
    logic [ATTR_W-1:0] r_attr;
    logic [PW-1:0]     r_at;
    logic [PW-1:0]     n_at;
    logic [PW-1:0]     r_pos;
    logic              r_move;
    logic [CHAR_W-1:0] r_rd_ch;
    logic [ATTR_W-1:0] r_rd_attr;
    logic              r_scrolled;

    // Cursor and sweep
    logic [AW-1:0]     r_cursor;
    logic [AW-1:0]     n_cursor;
    logic [PW-1:0]     cursor_ext;
    logic [AW-1:0]     r_sweep;

    // Newline row quotient
    logic [PROD_W-1:0] quot_prod;
    logic [PW-1:0]     r_q;

    // Memory ports
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [CELL_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [CELL_W-1:0] mem_rd_data;
    logic [ATTR_W-1:0] mem_rd_attr;

    logic              at_on_screen;
    logic              pos_on_screen;

    assign cursor_ext    = {{(PW - AW){1'b0}}, r_cursor};
    assign at_on_screen  = (r_at < CELLS_P);
    assign pos_on_screen = (r_pos < CELLS_P);
    assign mem_rd_attr   = mem_rd_data[CELL_W-1:CHAR_W];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_attr  <= RESET_DEFAULT_ATTR;
            r_fill_attr <= RESET_FILL_ATTR;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DEFAULT_ATTR: r_def_attr  <= i_cfg_data;
                CFG_FILL_ATTR:    r_fill_attr <= i_cfg_data;
                default:          r_def_attr  <= r_def_attr;
            endcase
        end
    end

    // Latch the item; tab stands for a blank, attribute 0 picks the default
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= t_cmd'(i_command);
            r_ch   <= (i_character == CH_TAB) ? CH_BLANK : i_character;
            r_pos  <= {{(PW - POS_W){1'b0}}, i_position};
            r_move <= i_move_cursor;
        end
    end

    // Effective attribute; reset value serves the power-up clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_CELL_ATTR;
        end else if (i_ctl.load) begin
            r_attr <= (i_attribute == '0) ? r_def_attr : i_attribute;
        end
    end

    // Working position; newline lands on the start of the next row
    always_comb begin
        case (i_ctl.at_op)
            AT_INC:     n_at = r_at + PW'(1);
            AT_DEC:     n_at = r_at - PW'(1);
            AT_NEWLINE: n_at = (r_q + PW'(1)) * COLS_P;
            default:    n_at = r_at;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_at <= i_use_cursor ? cursor_ext : {{(PW - POS_W){1'b0}}, i_position};
        end else begin
            r_at <= n_at;
        end
    end

    // Row of the working position: multiply by the reciprocal, keep the high part
    assign quot_prod = {{(PROD_W - PW){1'b0}}, r_at} * {{(PROD_W - PW - 1){1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_init) begin
            r_q <= {{(LOG_C - 1){1'b0}}, quot_prod[PROD_W-1:SHIFT]};
        end
    end

    // Cursor
    always_comb begin
        case (i_ctl.cur_op)
            CUR_ZERO: n_cursor = '0;
            CUR_SET:  n_cursor = pos_on_screen ? r_pos[AW-1:0] : LAST_CELL;
            CUR_MOVE: n_cursor = at_on_screen ? r_at[AW-1:0] : LAST_ROW_START;
            default:  n_cursor = r_cursor;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else begin
            r_cursor <= n_cursor;
        end
    end

    // Scroll flag
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_scrolled <= 1'b0;
        end else if (i_ctl.cur_op == CUR_MOVE) begin
            r_scrolled <= !at_on_screen;
        end
    end

    // Sweep counter for clear, scroll copy and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_ctl.load) begin
            r_sweep <= '0;
        end else if (i_ctl.sweep_inc) begin
            r_sweep <= r_sweep + AW'(1);
        end
    end

    // Read result of a read command
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rd_ch   <= '0;
            r_rd_attr <= '0;
        end else if (i_ctl.capture) begin
            r_rd_ch   <= mem_rd_data[CHAR_W-1:0];
            r_rd_attr <= mem_rd_attr;
        end
    end

    // Memory read address
    assign mem_rd_en = (i_ctl.rd != RD_NONE);

    always_comb begin
        case (i_ctl.rd)
            RD_AT:        mem_rd_addr = r_at[AW-1:0];
            RD_POS:       mem_rd_addr = r_pos[AW-1:0];
            RD_COPY:      mem_rd_addr = r_sweep + COLS_A;
            RD_COPY_NEXT: mem_rd_addr = r_sweep + COLS_A + AW'(1);
            default:      mem_rd_addr = r_sweep;
        endcase
    end

    // Memory write address and data
    assign mem_wr_en = (i_ctl.wr != WR_NONE);

    always_comb begin
        case (i_ctl.wr)
            WR_PUT: begin
                mem_wr_addr = r_at[AW-1:0];
                mem_wr_data = {r_attr, r_ch};
            end
            WR_PUT_KEEP: begin
                mem_wr_addr = r_at[AW-1:0];
                mem_wr_data = {mem_rd_attr, r_ch};
            end
            WR_BLANK_KEEP: begin
                mem_wr_addr = r_at[AW-1:0];
                mem_wr_data = {mem_rd_attr, CH_BLANK};
            end
            WR_SWEEP_BLANK: begin
                mem_wr_addr = r_sweep;
                mem_wr_data = {r_attr, CH_BLANK};
            end
            WR_COPY: begin
                mem_wr_addr = r_sweep;
                mem_wr_data = mem_rd_data;
            end
            WR_FILL: begin
                mem_wr_addr = r_sweep;
                mem_wr_data = {r_fill_attr, CH_BLANK};
            end
            default: begin
                mem_wr_addr = r_sweep;
                mem_wr_data = {r_attr, CH_BLANK};
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Status to the controller
    always_comb begin
        o_status.cmd             = r_cmd;
        o_status.is_newline      = (r_ch == CH_NEWLINE);
        o_status.is_backspace    = (r_ch == CH_BACKSPACE);
        o_status.is_printable    = (r_ch >= CH_PRINT_LOW) && (r_ch <= CH_PRINT_HIGH);
        o_status.at_zero         = (r_at == '0);
        o_status.at_on_screen    = at_on_screen;
        o_status.attr_zero       = (r_attr == '0);
        o_status.move            = r_move;
        o_status.pos_on_screen   = pos_on_screen;
        o_status.sweep_last      = (r_sweep == LAST_CELL);
        o_status.sweep_last_copy = (r_sweep == LAST_COPY);
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_ctl.emit;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            o_cursor         <= cursor_ext[POS_W-1:0];
            o_cell_character <= r_rd_ch;
            o_cell_attribute <= r_rd_attr;
            o_scrolled       <= r_scrolled;
        end
    end

endmodule

`default_nettype wire

>>> src/text_console_writer.sv
// Text console writer top level: controller (tcw_ctrl) and datapath
// (tcw_datapath, holding the screen RAM). Uses tcw_pkg.
//
//   Channel   Handshake                    Payload
//   --------  ---------------------------  ----------------------------------------
//   command   start & !busy                i_command, i_character, i_attribute,
//                                          i_use_cursor, i_position, i_move_cursor
//   result    o_done (one-cycle strobe)    o_cursor, o_cell_character,
//                                          o_cell_attribute, o_scrolled
//   config    i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item at a time. A printable put on screen writes its cell directly, or reads
// it first when the old attribute is kept; a read reads the cell unless past the last.
// Backspace steps back and, if on screen, reads the cell and writes a blank that
// keeps its attribute (nothing at cell zero); newline takes the row quotient, then
// steps to the row start. Clear walks every cell at one write per cycle; a scroll
// adds a copy and fill pass on the single RAM write port. After reset a clearing
// pass over every cell holds busy high; config writes are taken at any time. The
// result cannot stall.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [tcw_pkg::CMD_W-1:0]     i_command,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    i_attribute,
    input  wire logic                          i_use_cursor,
    input  wire logic [tcw_pkg::POS_W-1:0]     i_position,
    input  wire logic                          i_move_cursor,
    output logic                               o_done,
    output logic      [tcw_pkg::POS_W-1:0]     o_cursor,
    output logic      [tcw_pkg::CHAR_W-1:0]    o_cell_character,
    output logic      [tcw_pkg::ATTR_W-1:0]    o_cell_attribute,
    output logic                               o_scrolled,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data
);

    import tcw_pkg::*;

    t_ctl    ctl;
    t_status status;

    // Config registers accept a write every cycle
    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_character      (i_character),
        .i_attribute      (i_attribute),
        .i_use_cursor     (i_use_cursor),
        .i_position       (i_position),
        .i_move_cursor    (i_move_cursor),
        .i_ctl            (ctl),
        .o_status         (status),
        .o_done           (o_done),
        .o_cursor         (o_cursor),
        .o_cell_character (o_cell_character),
        .o_cell_attribute (o_cell_attribute),
        .o_scrolled       (o_scrolled)
    );

endmodule

`default_nettype wire
